// ----- src/i2r_pkg.sv -----
// Package for the integer to Roman numeral encoder: symbol table, ASCII codes,
// controller state type and the command/status words between controller and datapath.
// No dependencies.
package i2r_pkg;

    localparam int unsigned ValueW = 12;
    localparam int unsigned CharW  = 7;
    localparam int unsigned NumSym = 13;
    localparam int unsigned SymIdxW = $clog2(NumSym);
    localparam logic [ValueW-1:0] MaxValue = 12'd3999;

    localparam logic [CharW-1:0] ChrI    = 7'h49;
    localparam logic [CharW-1:0] ChrV    = 7'h56;
    localparam logic [CharW-1:0] ChrX    = 7'h58;
    localparam logic [CharW-1:0] ChrL    = 7'h4C;
    localparam logic [CharW-1:0] ChrC    = 7'h43;
    localparam logic [CharW-1:0] ChrD    = 7'h44;
    localparam logic [CharW-1:0] ChrM    = 7'h4D;
    localparam logic [CharW-1:0] ChrNone = 7'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PAIR,
        ST_BAD
    } state_t;

    // One entry of the greedy symbol table; pair entries emit c1 then c2.
    typedef struct packed {
        logic [ValueW-1:0] val;
        logic [CharW-1:0]  c1;
        logic [CharW-1:0]  c2;
        logic              pair;
    } sym_t;

    typedef struct packed {
        logic load;     // take value into the remainder register
        logic step;     // emit the first char of the picked symbol, subtract it
        logic second;   // emit the held second char of a pair
        logic bad;      // emit the single invalid word
    } cmd_t;

    typedef struct packed {
        logic value_bad;  // input value is zero or above the range
        logic sel_pair;   // picked symbol is a subtractive pair
        logic step_zero;  // remainder reaches zero after this step
        logic rem_zero;   // remainder is zero now
    } status_t;

    function automatic sym_t i2r_sym(input logic [SymIdxW-1:0] idx);
        sym_t s;
        unique case (idx)
            4'd0:    s = '{12'd1000, ChrM, ChrNone, 1'b0};
            4'd1:    s = '{12'd900,  ChrC, ChrM,    1'b1};
            4'd2:    s = '{12'd500,  ChrD, ChrNone, 1'b0};
            4'd3:    s = '{12'd400,  ChrC, ChrD,    1'b1};
            4'd4:    s = '{12'd100,  ChrC, ChrNone, 1'b0};
            4'd5:    s = '{12'd90,   ChrX, ChrC,    1'b1};
            4'd6:    s = '{12'd50,   ChrL, ChrNone, 1'b0};
            4'd7:    s = '{12'd40,   ChrX, ChrL,    1'b1};
            4'd8:    s = '{12'd10,   ChrX, ChrNone, 1'b0};
            4'd9:    s = '{12'd9,    ChrI, ChrX,    1'b1};
            4'd10:   s = '{12'd5,    ChrV, ChrNone, 1'b0};
            4'd11:   s = '{12'd4,    ChrI, ChrV,    1'b1};
            default: s = '{12'd1,    ChrI, ChrNone, 1'b0};
        endcase
        return s;
    endfunction

    // Largest symbol not above rem; falls back to I.
    function automatic logic [SymIdxW-1:0] i2r_pick(input logic [ValueW-1:0] rem);
        logic [SymIdxW-1:0] idx;
        idx = SymIdxW'(NumSym - 1);
        for (int i = NumSym - 1; i >= 0; i--) begin
            if (rem >= i2r_sym(SymIdxW'(i)).val) begin
                idx = SymIdxW'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- src/integer_to_roman_encoder.sv -----
// Top level of the integer to Roman numeral encoder: controller plus datapath.
// Depends on i2r_pkg, i2r_ctrl and i2r_dpath.
//
// Pulse start while busy is low to hand in a 12-bit value; the block then
// emits its Roman numeral one ASCII char per cycle, most significant first,
// each word shown for one cycle with char_valid high and last_char high on
// the final char. The receiver cannot stall, so sample every word on
// char_valid. A value of zero or above 3999 yields one word with invalid and
// last_char set and char_code zero. Busy is high while the controller steps
// through the numeral or the invalid word, and start is taken only while busy
// is low. The longest numeral, for 3888, has 15 chars. The pace is set by the
// greedy loop: each cycle the datapath picks the largest symbol of the table
// not above the remainder register and emits one char of it; a pair's second char is held and emitted on its own.
module integer_to_roman_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [i2r_pkg::ValueW-1:0]    value,
    output logic                          char_valid,
    output logic [i2r_pkg::CharW-1:0]     char_code,
    output logic                          last_char,
    output logic                          invalid
);
    import i2r_pkg::*;

    // commands down, status up; nothing else crosses between the two halves
    cmd_t    cmd;
    status_t sts;

    i2r_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    i2r_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .sts        (sts),
        .char_valid (char_valid),
        .char_code  (char_code),
        .last_char  (last_char),
        .invalid    (invalid)
    );

endmodule

// ----- src/i2r_ctrl.sv -----
// Controller of the integer to Roman numeral encoder: load, step, pair and invalid states.
// Depends on i2r_pkg.
module i2r_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  i2r_pkg::status_t sts,
    output i2r_pkg::cmd_t    cmd,
    output logic             busy
);
    import i2r_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sts.value_bad ? ST_BAD : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (sts.sel_pair)
                begin
                    state_next = ST_PAIR;
                end
                else if (sts.step_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAIR:
            begin
                state_next = sts.rem_zero ? ST_IDLE : ST_RUN;
            end
            ST_BAD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_RUN:  cmd.step   = 1'b1;
            ST_PAIR: cmd.second = 1'b1;
            ST_BAD:  cmd.bad    = 1'b1;
            default: busy       = 1'b1;
        endcase
    end

endmodule

// ----- src/i2r_dpath.sv -----
// Datapath of the integer to Roman numeral encoder: remainder, symbol pick, output word.
// Depends on i2r_pkg.
module i2r_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [i2r_pkg::ValueW-1:0]    value,
    input  i2r_pkg::cmd_t                 cmd,
    output i2r_pkg::status_t              sts,
    output logic                          char_valid,
    output logic [i2r_pkg::CharW-1:0]     char_code,
    output logic                          last_char,
    output logic                          invalid
);
    import i2r_pkg::*;

    logic [ValueW-1:0]  rem_reg, rem_next;
    logic [CharW-1:0]   pend_reg, pend_next;
    logic               strobe_reg, strobe_next;
    logic [CharW-1:0]   char_reg, char_next;
    logic               last_reg, last_next;
    logic               invalid_reg, invalid_next;

    logic [SymIdxW-1:0] sel;
    sym_t               sym;
    logic [ValueW-1:0]  rem_sub;

    assign sel     = i2r_pick(rem_reg);
    assign sym     = i2r_sym(sel);
    assign rem_sub = rem_reg - sym.val;

    assign sts.value_bad = (value == '0) || (value > MaxValue);
    assign sts.sel_pair  = sym.pair;
    assign sts.step_zero = (rem_sub == '0);
    assign sts.rem_zero  = (rem_reg == '0);

    always_comb
    begin
        rem_next     = rem_reg;
        pend_next    = pend_reg;
        strobe_next  = cmd.step | cmd.second | cmd.bad;
        char_next    = ChrNone;
        last_next    = 1'b0;
        invalid_next = cmd.bad;
        if (cmd.load)
        begin
            rem_next = value;
        end
        if (cmd.step)
        begin
            // subtract the whole symbol now; a pair's second char waits in pend
            rem_next  = rem_sub;
            pend_next = sym.c2;
            char_next = sym.c1;
            last_next = !sym.pair && (rem_sub == '0);
        end
        if (cmd.second)
        begin
            char_next = pend_reg;
            last_next = (rem_reg == '0);
        end
        if (cmd.bad)
        begin
            last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        pend_reg    <= pend_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
        invalid_reg <= invalid_next;
    end

    assign char_valid = strobe_reg;
    assign char_code  = char_reg;
    assign last_char  = last_reg;
    assign invalid    = invalid_reg;

    a_invalid_single: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && invalid_reg) |-> (last_reg && char_reg == ChrNone))
        else $error("invalid word must be a single last word with no char");

    a_char_present: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !invalid_reg) |-> (char_reg != ChrNone))
        else $error("valid numeral word carries no char");

    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (rem_reg != '0))
        else $error("step issued with empty remainder");

    a_strobe_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step || cmd.second || cmd.bad) |=> strobe_reg)
        else $error("emit command did not produce a word");

endmodule
